// File: rtl/snf_seq_pkg.sv
`default_nettype none

package snf_seq_pkg;

  localparam int unsigned ADDRESS_BITS = 24;
  localparam int unsigned COUNT_BITS   = 24;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    CMD_ID_READ   = 3'd0,
    CMD_DATA_READ = 3'd1,
    CMD_ERASE     = 3'd2,
    CMD_PROGRAM   = 3'd3,
    CMD_XCHG      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ID      = 2'd0,
    OP_READ    = 2'd1,
    OP_ERASE   = 2'd2,
    OP_PROGRAM = 2'd3
  } op_e;

  localparam logic [7:0] FL_READ_ID  = 8'h90;
  localparam logic [7:0] FL_READ     = 8'h03;
  localparam logic [7:0] FL_WREN     = 8'h06;
  localparam logic [7:0] FL_WRDI     = 8'h04;
  localparam logic [7:0] FL_RDSR     = 8'h05;
  localparam logic [7:0] FL_ERASE    = 8'h20;
  localparam logic [7:0] FL_PROGRAM  = 8'h02;
  localparam logic [7:0] FL_ID_ADDR0 = 8'h00;
  localparam logic [7:0] FL_ID_ADDR1 = 8'h08;
  localparam logic [7:0] FL_DUMMY    = 8'hFF;

  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_ID_OP   = 16'h0002,
    PH_ID_A2   = 16'h0004,
    PH_ID_A1   = 16'h0008,
    PH_ID_A0   = 16'h0010,
    PH_ID_M    = 16'h0020,
    PH_ID_D    = 16'h0040,
    PH_WREN    = 16'h0080,
    PH_OP      = 16'h0100,
    PH_A2      = 16'h0200,
    PH_A1      = 16'h0400,
    PH_A0      = 16'h0800,
    PH_DATA    = 16'h1000,
    PH_POLL_OP = 16'h2000,
    PH_POLL_ST = 16'h4000,
    PH_WRDI    = 16'h8000
  } phase_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] flash_address;
    logic [23:0] byte_count;
    logic [7:0]  write_byte;
    logic [7:0]  miso_byte;
  } item_t;

  typedef struct packed {
    phase_e                  phase;
    op_e                     operation;
    logic [ADDRESS_BITS-1:0] address_hold;
    logic [COUNT_BITS-1:0]   bytes_left;
    logic [7:0]              maker_hold;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       send_valid;
    logic       deselect_after;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] maker_id;
    logic [7:0] device_id;
    logic       id_valid;
    logic       busy_res;
    logic       op_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/spi_nor_flash_command_sequencer_core.sv
`default_nettype none

// Serial NOR flash command sequencer. Send one request item (tuser 0..3) to
// start an ID read, data read, sector erase or page program, then one
// exchange item (tuser 4) for every byte the bus has shifted, carrying the
// byte returned by the flash. Each item gives exactly one result item naming
// the next byte to send and whether chip select rises after it, plus any read
// data, ID bytes, busy and done flags. The block sustains one item per clock
// while the output side is not stalled: an input register, combinational
// sequencer decode against the state registers, and a result register that
// holds each result until the output side takes it.
module spi_nor_flash_command_sequencer_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // flash_address[23:0], byte_count[47:24], write_byte[55:48], miso_byte[63:56]
  input  wire  [snf_seq_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // cmd[2:0]
  input  wire  [snf_seq_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // mosi_byte[7:0], send_valid[8], deselect_after[9], read_byte[17:10],
  // read_valid[18], maker_id[26:19], device_id[34:27], id_valid[35],
  // busy_res[36], op_done[37], zero[39:38]
  output logic [snf_seq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import snf_seq_pkg::*;

  logic       in_valid_q;
  item_t      item_q;
  seq_state_t state_q, state_d;
  result_t    res_d, res_q;
  logic       out_valid_q;
  logic       advance;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.cmd           <= s_axis_tuser_i;
      item_q.flash_address <= s_axis_tdata_i[23:0];
      item_q.byte_count    <= s_axis_tdata_i[47:24];
      item_q.write_byte    <= s_axis_tdata_i[55:48];
      item_q.miso_byte     <= s_axis_tdata_i[63:56];
    end
  end

  snf_seq_logic u_logic (
    .item_i (item_q),
    .cur_i  (state_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // update state only when the decoded item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= PH_IDLE;
      state_q.operation    <= OP_ID;
      state_q.address_hold <= '0;
      state_q.bytes_left   <= '0;
      state_q.maker_hold   <= '0;
      out_valid_q          <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.op_done, res_q.busy_res, res_q.id_valid,
                            res_q.device_id, res_q.maker_id, res_q.read_valid,
                            res_q.read_byte, res_q.deselect_after, res_q.send_valid,
                            res_q.mosi_byte};

  a_desel_needs_send : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.deselect_after) |-> res_q.send_valid)
    else $error("chip select release without a byte to send");

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.op_done) |-> (!res_q.busy_res && !res_q.send_valid))
    else $error("request completed while still busy or sending");

  a_id_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.id_valid) |-> res_q.op_done)
    else $error("identifier bytes outside the completing item");

  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(item_q)))
    else $error("stalled input item lost");

endmodule

`default_nettype wire

// File: rtl/snf_seq_logic.sv
`default_nettype none

module snf_seq_logic (
  input  snf_seq_pkg::item_t      item_i,
  input  snf_seq_pkg::seq_state_t cur_i,
  output snf_seq_pkg::seq_state_t nxt_o,
  output snf_seq_pkg::result_t    res_o
);
  import snf_seq_pkg::*;

  logic [COUNT_BITS-1:0] bytes_dec;
  logic                  last_addr_ends;

  assign bytes_dec      = cur_i.bytes_left - COUNT_BITS'(1);
  assign last_addr_ends = (cur_i.operation == OP_ERASE) || (cur_i.bytes_left == '0);

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;

    if (cur_i.phase == PH_IDLE) begin
      if (item_i.cmd <= CMD_PROGRAM) begin
        nxt_o.operation    = op_e'(item_i.cmd[1:0]);
        nxt_o.address_hold = ADDRESS_BITS'(item_i.flash_address);
        nxt_o.bytes_left   = COUNT_BITS'(item_i.byte_count);
        res_o.send_valid   = 1'b1;
        case (item_i.cmd)
          CMD_ID_READ: begin
            res_o.mosi_byte = FL_READ_ID;
            nxt_o.phase     = PH_ID_OP;
          end
          CMD_DATA_READ: begin
            res_o.mosi_byte = FL_READ;
            nxt_o.phase     = PH_OP;
          end
          default: begin
            res_o.mosi_byte      = FL_WREN;
            res_o.deselect_after = 1'b1;
            nxt_o.phase          = PH_WREN;
          end
        endcase
      end
    end else if (item_i.cmd == CMD_XCHG) begin
      case (cur_i.phase)
        PH_ID_OP: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = FL_ID_ADDR0;
          nxt_o.phase      = PH_ID_A2;
        end
        PH_ID_A2: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = FL_ID_ADDR0;
          nxt_o.phase      = PH_ID_A1;
        end
        PH_ID_A1: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = FL_ID_ADDR0;
          nxt_o.phase      = PH_ID_A0;
        end
        PH_ID_A0: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = FL_ID_ADDR1;
          nxt_o.phase      = PH_ID_M;
        end
        PH_ID_M: begin
          // clock out the device id byte while keeping the maker id
          nxt_o.maker_hold     = item_i.miso_byte;
          res_o.send_valid     = 1'b1;
          res_o.mosi_byte      = FL_WRDI;
          res_o.deselect_after = 1'b1;
          nxt_o.phase          = PH_ID_D;
        end
        PH_ID_D: begin
          res_o.maker_id  = cur_i.maker_hold;
          res_o.device_id = item_i.miso_byte;
          res_o.id_valid  = 1'b1;
          res_o.op_done   = 1'b1;
          nxt_o.phase     = PH_IDLE;
        end
        PH_WREN: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = (cur_i.operation == OP_ERASE) ? FL_ERASE : FL_PROGRAM;
          nxt_o.phase      = PH_OP;
        end
        PH_OP: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = cur_i.address_hold[23:16];
          nxt_o.phase      = PH_A2;
        end
        PH_A2: begin
          res_o.send_valid = 1'b1;
          res_o.mosi_byte  = cur_i.address_hold[15:8];
          nxt_o.phase      = PH_A1;
        end
        PH_A1: begin
          res_o.send_valid     = 1'b1;
          res_o.mosi_byte      = cur_i.address_hold[7:0];
          res_o.deselect_after = last_addr_ends;
          nxt_o.phase          = PH_A0;
        end
        PH_A0, PH_DATA: begin
          if ((cur_i.phase == PH_DATA) && (cur_i.operation == OP_READ)) begin
            res_o.read_byte  = item_i.miso_byte;
            res_o.read_valid = 1'b1;
          end
          if ((cur_i.phase == PH_A0) ? last_addr_ends : (cur_i.bytes_left == '0)) begin
            if (cur_i.operation == OP_READ) begin
              res_o.op_done = 1'b1;
              nxt_o.phase   = PH_IDLE;
            end else begin
              res_o.send_valid = 1'b1;
              res_o.mosi_byte  = FL_RDSR;
              nxt_o.phase      = PH_POLL_OP;
            end
          end else begin
            nxt_o.bytes_left     = bytes_dec;
            res_o.send_valid     = 1'b1;
            res_o.mosi_byte      = (cur_i.operation == OP_READ) ? FL_DUMMY : item_i.write_byte;
            res_o.deselect_after = (bytes_dec == '0);
            nxt_o.phase          = PH_DATA;
          end
        end
        PH_POLL_OP: begin
          res_o.send_valid     = 1'b1;
          res_o.mosi_byte      = FL_DUMMY;
          res_o.deselect_after = 1'b1;
          nxt_o.phase          = PH_POLL_ST;
        end
        PH_POLL_ST: begin
          res_o.send_valid = 1'b1;
          // poll again while the write-in-progress bit is set
          if (item_i.miso_byte[0]) begin
            res_o.mosi_byte = FL_RDSR;
            nxt_o.phase     = PH_POLL_OP;
          end else begin
            res_o.mosi_byte      = FL_WRDI;
            res_o.deselect_after = 1'b1;
            nxt_o.phase          = PH_WRDI;
          end
        end
        PH_WRDI: begin
          res_o.op_done = 1'b1;
          nxt_o.phase   = PH_IDLE;
        end
        default: begin
          nxt_o.phase = PH_IDLE;
        end
      endcase
    end

    res_o.busy_res = (nxt_o.phase != PH_IDLE);
  end

endmodule

`default_nettype wire

// File: tb/snf_seq_checker.sv
module snf_seq_checker (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  input  wire                                 s_axis_tready_i,
  // flash_address[23:0], byte_count[47:24], write_byte[55:48], miso_byte[63:56]
  input  wire  [snf_seq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // cmd[2:0]
  input  wire  [snf_seq_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  input  wire                                 m_axis_tvalid_i,
  input  wire                                 m_axis_tready_i,
  // mosi_byte[7:0], send_valid[8], deselect_after[9], read_byte[17:10],
  // read_valid[18], maker_id[26:19], device_id[34:27], id_valid[35],
  // busy_res[36], op_done[37], zero[39:38]
  input  wire  [snf_seq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_i,
  output int                                  outstanding_o,
  output int                                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import snf_seq_pkg::*;

  localparam int MAX_PRINTED = 20;

  phase_e                  fl_phase;
  op_e                     fl_op;
  logic [ADDRESS_BITS-1:0] addr_hold;
  logic [COUNT_BITS-1:0]   left_count;
  logic [7:0]              maker_hold;

  result_t pending_results[$];
  int      mismatches;
  int      result_index;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch on result %0d: %s got %0h expected %0h",
               result_index, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch(what, {16'd0, got}, {16'd0, want});
    end
  endtask

  function automatic result_t shift_out(input result_t r, input logic [7:0] b,
                                        input logic desel);
    result_t o;
    o = r;
    o.mosi_byte      = b;
    o.send_valid     = 1'b1;
    o.deselect_after = desel;
    return o;
  endfunction

  // Count down and hand out the next data byte; reads clock out dummies.
  function automatic result_t next_data(input result_t r, input logic [7:0] wbyte);
    left_count = left_count - 1'b1;
    fl_phase   = PH_DATA;
    return shift_out(r, (fl_op == OP_READ) ? FL_DUMMY : wbyte, left_count == '0);
  endfunction

  // A read ends here; erase and program go on to status polling.
  function automatic result_t close_transfer(input result_t r);
    result_t o;
    o = r;
    if (fl_op == OP_READ) begin
      o.op_done = 1'b1;
      fl_phase  = PH_IDLE;
    end else begin
      o        = shift_out(o, FL_RDSR, 1'b0);
      fl_phase = PH_POLL_OP;
    end
    return o;
  endfunction

  function automatic result_t next_bus_result(input logic [2:0] cmd,
                                              input logic [23:0] addr,
                                              input logic [23:0] cnt,
                                              input logic [7:0] wbyte,
                                              input logic [7:0] miso);
    result_t r;
    r = '0;
    if (fl_phase == PH_IDLE) begin
      if (cmd <= CMD_PROGRAM) begin
        fl_op      = op_e'(cmd[1:0]);
        addr_hold  = addr;
        left_count = cnt;
        case (cmd)
          CMD_ID_READ: begin
            r        = shift_out(r, FL_READ_ID, 1'b0);
            fl_phase = PH_ID_OP;
          end
          CMD_DATA_READ: begin
            r        = shift_out(r, FL_READ, 1'b0);
            fl_phase = PH_OP;
          end
          default: begin
            r        = shift_out(r, FL_WREN, 1'b1);
            fl_phase = PH_WREN;
          end
        endcase
      end
    end else if (cmd == CMD_XCHG) begin
      case (fl_phase)
        PH_ID_OP: begin r = shift_out(r, FL_ID_ADDR0, 1'b0); fl_phase = PH_ID_A2; end
        PH_ID_A2: begin r = shift_out(r, FL_ID_ADDR0, 1'b0); fl_phase = PH_ID_A1; end
        PH_ID_A1: begin r = shift_out(r, FL_ID_ADDR0, 1'b0); fl_phase = PH_ID_A0; end
        PH_ID_A0: begin r = shift_out(r, FL_ID_ADDR1, 1'b0); fl_phase = PH_ID_M; end
        PH_ID_M: begin
          // maker byte arrives; the frame closes with 0x04 in the last slot
          maker_hold = miso;
          r          = shift_out(r, FL_WRDI, 1'b1);
          fl_phase   = PH_ID_D;
        end
        PH_ID_D: begin
          r.maker_id  = maker_hold;
          r.device_id = miso;
          r.id_valid  = 1'b1;
          r.op_done   = 1'b1;
          fl_phase    = PH_IDLE;
        end
        PH_WREN: begin
          r = shift_out(r, (fl_op == OP_ERASE) ? FL_ERASE : FL_PROGRAM, 1'b0);
          fl_phase = PH_OP;
        end
        PH_OP: begin r = shift_out(r, addr_hold[23:16], 1'b0); fl_phase = PH_A2; end
        PH_A2: begin r = shift_out(r, addr_hold[15:8], 1'b0); fl_phase = PH_A1; end
        PH_A1: begin
          r = shift_out(r, addr_hold[7:0], fl_op == OP_ERASE || left_count == '0);
          fl_phase = PH_A0;
        end
        PH_A0: begin
          if (fl_op == OP_ERASE || left_count == '0) r = close_transfer(r);
          else r = next_data(r, wbyte);
        end
        PH_DATA: begin
          if (fl_op == OP_READ) begin
            r.read_byte  = miso;
            r.read_valid = 1'b1;
          end
          if (left_count == '0) r = close_transfer(r);
          else r = next_data(r, wbyte);
        end
        PH_POLL_OP: begin r = shift_out(r, FL_DUMMY, 1'b1); fl_phase = PH_POLL_ST; end
        PH_POLL_ST: begin
          // keep polling while the busy bit is set
          if (miso[0]) begin
            r        = shift_out(r, FL_RDSR, 1'b0);
            fl_phase = PH_POLL_OP;
          end else begin
            r        = shift_out(r, FL_WRDI, 1'b1);
            fl_phase = PH_WRDI;
          end
        end
        PH_WRDI: begin
          r.op_done = 1'b1;
          fl_phase  = PH_IDLE;
        end
        default: fl_phase = PH_IDLE;
      endcase
    end
    r.busy_res = (fl_phase != PH_IDLE);
    return r;
  endfunction

  function automatic result_t unpack_result(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.mosi_byte      = d[7:0];
    r.send_valid     = d[8];
    r.deselect_after = d[9];
    r.read_byte      = d[17:10];
    r.read_valid     = d[18];
    r.maker_id       = d[26:19];
    r.device_id      = d[34:27];
    r.id_valid       = d[35];
    r.busy_res       = d[36];
    r.op_done        = d[37];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      fl_phase      = PH_IDLE;
      fl_op         = OP_ID;
      addr_hold     = '0;
      left_count    = '0;
      maker_hold    = '0;
      pending_results.delete();
      mismatches    = 0;
      result_index  = 0;
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = unpack_result(m_axis_tdata_i);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", {14'd0, m_axis_tdata_i[9:0]}, '0);
        end else begin
          want = pending_results.pop_front();
          check_field("mosi_byte", got.mosi_byte, want.mosi_byte);
          check_field("send_valid", 8'(got.send_valid), 8'(want.send_valid));
          check_field("deselect_after", 8'(got.deselect_after), 8'(want.deselect_after));
          check_field("read_byte", got.read_byte, want.read_byte);
          check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
          check_field("maker_id", got.maker_id, want.maker_id);
          check_field("device_id", got.device_id, want.device_id);
          check_field("id_valid", 8'(got.id_valid), 8'(want.id_valid));
          check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          check_field("op_done", 8'(got.op_done), 8'(want.op_done));
        end
        result_index++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_results.push_back(next_bus_result(s_axis_tuser_i,
                                                  s_axis_tdata_i[23:0],
                                                  s_axis_tdata_i[47:24],
                                                  s_axis_tdata_i[55:48],
                                                  s_axis_tdata_i[63:56]));
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// File: tb/tb_spi_nor_flash_command_sequencer_core.sv
module tb_spi_nor_flash_command_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import snf_seq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MID_ITEMS    = 700;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned TOTAL_ITEMS  = 1530;
  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  localparam logic [23:0] ADDR_TOP     = 24'hFF_FFFF;
  localparam logic [23:0] COUNT_TOP    = 24'hFF_FFFF;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  int          outstanding;
  int          mismatches;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          quiet_tail = 1'b0;

  spi_nor_flash_command_sequencer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  snf_seq_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .outstanding_o   (outstanding),
    .errors_o        (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts outside calm windows and the tail.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && (cycles % 256) >= 64 && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic item_t rand_item(input logic [2:0] cmd);
    item_t it;
    it.cmd           = cmd;
    it.flash_address = 24'($urandom);
    it.byte_count    = 24'($urandom);
    it.write_byte    = 8'($urandom);
    it.miso_byte     = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (!quiet_tail && (cycles % 512) >= 128 && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tuser_i  <= it.cmd;
    s_axis_tdata_i  <= {it.miso_byte, it.write_byte, it.byte_count, it.flash_address};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // One bus byte done; a stray request or spare code may slip in first.
  task automatic exchange(input logic [7:0] miso, input bit noisy);
    item_t it;
    if (noisy && $urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 1) it = rand_item(3'($urandom_range(CMD_ID_READ, CMD_PROGRAM)));
      else it = rand_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
      send_item(it);
    end
    it = rand_item(CMD_XCHG);
    it.miso_byte = miso;
    send_item(it);
  endtask

  task automatic run_request(input logic [2:0] cmd, input logic [23:0] addr,
                             input logic [23:0] cnt, input int busy_polls,
                             input bit noisy);
    item_t it;
    it = rand_item(cmd);
    it.flash_address = addr;
    it.byte_count    = cnt;
    send_item(it);
    case (cmd)
      CMD_ID_READ:   repeat (6) exchange(8'($urandom), noisy);
      CMD_DATA_READ: repeat (4 + int'(cnt)) exchange(8'($urandom), noisy);
      default: begin
        repeat ((cmd == CMD_PROGRAM) ? 5 + int'(cnt) : 5) exchange(8'($urandom), noisy);
        // status answers: busy bit set until the last poll
        for (int i = 0; i <= busy_polls; i++) begin
          exchange(8'($urandom), noisy);
          exchange({7'($urandom), 1'(i < busy_polls)}, noisy);
        end
        exchange(8'($urandom), noisy);
      end
    endcase
  endtask

  task automatic random_round();
    logic [2:0]  op;
    logic [23:0] addr;
    logic [23:0] cnt;
    if ($urandom_range(0, 99) < 8) begin
      send_item(rand_item(3'($urandom_range(CMD_XCHG, CMD_SPARE_HI))));
    end else begin
      op   = 3'($urandom_range(CMD_ID_READ, CMD_PROGRAM));
      addr = 24'($urandom);
      if ($urandom_range(0, 7) == 0) addr = ($urandom_range(0, 1) == 1) ? ADDR_TOP : '0;
      cnt = ($urandom_range(0, 31) == 0) ? 24'($urandom_range(20, 48))
                                         : 24'($urandom_range(0, 5));
      // erase ignores the count, so it can carry any value
      if (op == CMD_ERASE) cnt = 24'($urandom);
      run_request(op, addr, cnt, $urandom_range(0, 3), 1'b1);
    end
  endtask

  initial begin
    item_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    it = '1;
    it.cmd = CMD_XCHG;
    send_item(it);
    it = '0;
    it.cmd = CMD_SPARE_HI;
    send_item(it);

    it = rand_item(CMD_ID_READ);
    it.flash_address = '0;
    it.byte_count    = '0;
    send_item(it);
    exchange(8'h00, 1'b0);
    it = '1;
    it.cmd = CMD_DATA_READ;
    send_item(it);
    exchange(8'hFF, 1'b0);
    exchange(8'h00, 1'b0);
    exchange(8'hFF, 1'b0);
    exchange(8'hFF, 1'b0);
    exchange(8'h00, 1'b0);

    run_request(CMD_DATA_READ, ADDR_TOP, '0, 0, 1'b0);
    run_request(CMD_ERASE, '0, COUNT_TOP, 1, 1'b0);
    wait_drained();

    while (items_sent < MID_ITEMS) random_round();
    wait_drained();
    while (items_sent < RANDOM_ITEMS) random_round();
    quiet_tail = 1'b1;
    while (items_sent < TOTAL_ITEMS) random_round();

    // full count: leave the program running after a few data bytes
    it = rand_item(CMD_PROGRAM);
    it.byte_count = COUNT_TOP;
    send_item(it);
    repeat (25) exchange(8'($urandom), 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: spi_nor_flash_command_sequencer_core.f
rtl/snf_seq_pkg.sv
rtl/snf_seq_logic.sv
rtl/spi_nor_flash_command_sequencer_core.sv
tb/snf_seq_checker.sv
tb/tb_spi_nor_flash_command_sequencer_core.sv
